>>> rtl/ttc_pkg.sv
// Shared types and constants for the trigger sync block.
`default_nettype none
package ttc_pkg;

  localparam int unsigned CODE_W  = 6;
  localparam int unsigned OUT_W   = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_A_W = 3;

  // opcodes the block comes out of reset with
  localparam logic [CODE_W-1:0] DEF_OP_RESYNC = 6'd3;
  localparam logic [CODE_W-1:0] DEF_OP_BC0    = 6'd1;
  localparam logic [CODE_W-1:0] DEF_OP_START  = 6'd6;
  localparam logic [CODE_W-1:0] DEF_OP_STOP   = 6'd7;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_OFFSET     = 3'd0,
    CFG_LONG_ORBIT = 3'd1,
    CFG_OP_RESYNC  = 3'd2,
    CFG_OP_BC0     = 3'd3,
    CFG_OP_START   = 3'd4,
    CFG_OP_STOP    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_STOP   = 2'd0,
    ST_RESYNC = 2'd1,
    ST_WAIT   = 2'd2,
    ST_RUN    = 2'd3
  } run_state_e;

  typedef struct packed {
    logic resync;
    logic bc0;
    logic start;
    logic stop;
  } cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] resync;
    logic [CODE_W-1:0] bc0;
    logic [CODE_W-1:0] start;
    logic [CODE_W-1:0] stop;
  } opcodes_t;

endpackage
`default_nettype wire

>>> rtl/ttc_cmd_decode.sv
// Strobed command compare against the four configured opcodes.
`default_nettype none
module ttc_cmd_decode (
  input  wire logic [ttc_pkg::CODE_W-1:0] code_i,
  input  wire logic                       strobe_i,
  input  wire ttc_pkg::opcodes_t          ops_i,
  output ttc_pkg::cmd_t                   cmd_o
);

  // several opcodes may be equal; all matches are flagged
  assign cmd_o.resync = strobe_i && (code_i == ops_i.resync);
  assign cmd_o.bc0    = strobe_i && (code_i == ops_i.bc0);
  assign cmd_o.start  = strobe_i && (code_i == ops_i.start);
  assign cmd_o.stop   = strobe_i && (code_i == ops_i.stop);

endmodule
`default_nettype wire

>>> rtl/ttc_sync_fsm.sv
// Run-state machine with registered trigger-stop and DAQ reset flags.
`default_nettype none
module ttc_sync_fsm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          hard_reset_n_i,
  input  wire logic          test_enable_i,
  input  wire ttc_pkg::cmd_t cmd_i,
  output logic               stop_flag_o,
  output logic               daq_flag_o
);

  ttc_pkg::run_state_e state_q, state_d;
  logic stop_q, stop_d;
  logic daq_q, daq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttc_pkg::ST_STOP;
      stop_q  <= 1'b1;
      daq_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      stop_q  <= stop_d;
      daq_q   <= daq_d;
    end
  end

  always_comb begin
    state_d = state_q;
    stop_d  = 1'b0;
    daq_d   = 1'b0;
    if (!hard_reset_n_i) begin
      state_d = ttc_pkg::ST_STOP;
      stop_d  = 1'b1;
      daq_d   = 1'b1;
    end else begin
      unique case (state_q)
        ttc_pkg::ST_STOP: begin
          stop_d = 1'b1;
          if (cmd_i.resync)     state_d = ttc_pkg::ST_RESYNC;
          else if (cmd_i.start) state_d = ttc_pkg::ST_WAIT;
        end
        ttc_pkg::ST_RESYNC: begin
          stop_d  = 1'b1;
          daq_d   = 1'b1;
          state_d = ttc_pkg::ST_WAIT;
        end
        ttc_pkg::ST_WAIT: begin
          stop_d = 1'b1;
          if (cmd_i.bc0)         state_d = ttc_pkg::ST_RUN;
          else if (cmd_i.resync) state_d = ttc_pkg::ST_RESYNC;
          else if (cmd_i.stop)   state_d = ttc_pkg::ST_STOP;
        end
        default: begin
          if (cmd_i.stop)        state_d = ttc_pkg::ST_STOP;
          else if (cmd_i.resync) state_d = ttc_pkg::ST_RESYNC;
        end
      endcase
      if (test_enable_i) stop_d = 1'b0;
    end
  end

  assign stop_flag_o = stop_q;
  assign daq_flag_o  = daq_q;

endmodule
`default_nettype wire

>>> rtl/ttc_bx_counter.sv
// Bunch-crossing counter with orbit wrap, BC0 load and BC0 capture.
`default_nettype none
module ttc_bx_counter #(
  parameter int unsigned COUNT_WIDTH = 12,
  parameter int unsigned LONG_ORBIT  = 3564,
  parameter int unsigned SHORT_ORBIT = 924
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic                   hard_reset_n_i,
  input  wire logic                   bc0_i,
  input  wire logic                   long_orbit_i,
  input  wire logic [COUNT_WIDTH-1:0] offset_i,
  output logic      [COUNT_WIDTH-1:0] count_o,
  output logic      [COUNT_WIDTH-1:0] captured_o
);

  localparam logic [COUNT_WIDTH-1:0] LongTc  = COUNT_WIDTH'(LONG_ORBIT - 1);
  localparam logic [COUNT_WIDTH-1:0] ShortTc = COUNT_WIDTH'(SHORT_ORBIT - 1);

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] cap_q, cap_d;
  logic [COUNT_WIDTH-1:0] term;

  assign term = long_orbit_i ? LongTc : ShortTc;

  // the offset is loaded only on hard reset and on BC0; the resync state has no offset load
  always_comb begin
    cap_d = cap_q;
    if (!hard_reset_n_i) begin
      cnt_d = offset_i;
    end else if (bc0_i) begin
      cap_d = cnt_q;
      cnt_d = offset_i;
    end else if (cnt_q == term) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
      cap_q <= cap_d;
    end
  end

  assign count_o    = cnt_q;
  assign captured_o = cap_q;

endmodule
`default_nettype wire

>>> rtl/ttc_trigger_sync_fsm_unit.sv
// Top level: TTC command decode, run-state machine and bunch-crossing counter.
// An accepted item's result is valid in the cycle after it is accepted.
// Throughput: one item per cycle; in_ready_o stays high while the result
//   register is empty or being drained in the same cycle.
// Reset (rst_ni low, async): config registers to defaults, stop state,
//   trigger stopped, counter and capture zero, no result pending.
`default_nettype none
module ttc_trigger_sync_fsm_unit #(
  parameter int unsigned COUNT_WIDTH = 12,
  parameter int unsigned LONG_ORBIT  = 3564,
  parameter int unsigned SHORT_ORBIT = 924
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [ttc_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  wire logic [ttc_pkg::CFG_W-1:0]     cfg_data_i,
  // input items (one per clock tick of the machine)
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          hard_reset_n_i,
  input  wire logic                          test_enable_i,
  input  wire logic [ttc_pkg::CODE_W-1:0]    command_code_i,
  input  wire logic                          command_strobe_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ttc_pkg::OUT_W-1:0]          crossing_count_o,
  output logic                               daq_counter_reset_o,
  output logic                               trigger_stopped_o,
  output logic                               resync_seen_o,
  output logic                               bc0_seen_o,
  output logic                               start_seen_o,
  output logic                               stop_seen_o,
  output logic [ttc_pkg::OUT_W-1:0]          count_before_bc0_o
);

  // common width for moving between the counter and the 12-bit ports
  localparam int unsigned XW = (COUNT_WIDTH > ttc_pkg::OUT_W) ? COUNT_WIDTH : ttc_pkg::OUT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ttc_pkg::CFG_W-1:0] offset_q;
  logic                      long_orbit_q;
  ttc_pkg::opcodes_t         ops_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      long_orbit_q <= 1'b1;
      ops_q.resync <= ttc_pkg::DEF_OP_RESYNC;
      ops_q.bc0    <= ttc_pkg::DEF_OP_BC0;
      ops_q.start  <= ttc_pkg::DEF_OP_START;
      ops_q.stop   <= ttc_pkg::DEF_OP_STOP;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ttc_pkg::CFG_OFFSET:     offset_q     <= cfg_data_i;
        ttc_pkg::CFG_LONG_ORBIT: long_orbit_q <= cfg_data_i[0];
        ttc_pkg::CFG_OP_RESYNC:  ops_q.resync <= cfg_data_i[ttc_pkg::CODE_W-1:0];
        ttc_pkg::CFG_OP_BC0:     ops_q.bc0    <= cfg_data_i[ttc_pkg::CODE_W-1:0];
        ttc_pkg::CFG_OP_START:   ops_q.start  <= cfg_data_i[ttc_pkg::CODE_W-1:0];
        ttc_pkg::CFG_OP_STOP:    ops_q.stop   <= cfg_data_i[ttc_pkg::CODE_W-1:0];
        default: ; // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The state registers double as the result register: they only
  // move on accept, and accept needs the result slot empty or freeing up.
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Decode, state machine, counter
  // ---------------------------------------------------------------------------
  ttc_pkg::cmd_t cmd;

  ttc_cmd_decode u_decode (
    .code_i   (command_code_i),
    .strobe_i (command_strobe_i),
    .ops_i    (ops_q),
    .cmd_o    (cmd)
  );

  ttc_sync_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_fire),
    .hard_reset_n_i (hard_reset_n_i),
    .test_enable_i  (test_enable_i),
    .cmd_i          (cmd),
    .stop_flag_o    (trigger_stopped_o),
    .daq_flag_o     (daq_counter_reset_o)
  );

  logic [XW-1:0]          offset_x;
  logic [COUNT_WIDTH-1:0] offset_c;
  logic [COUNT_WIDTH-1:0] count_c;
  logic [COUNT_WIDTH-1:0] cap_c;
  logic [XW-1:0]          count_x;
  logic [XW-1:0]          cap_x;

  // offset is truncated or zero-extended to the counter width
  assign offset_x = XW'(offset_q);
  assign offset_c = offset_x[COUNT_WIDTH-1:0];

  ttc_bx_counter #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .LONG_ORBIT  (LONG_ORBIT),
    .SHORT_ORBIT (SHORT_ORBIT)
  ) u_counter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_fire),
    .hard_reset_n_i (hard_reset_n_i),
    .bc0_i          (cmd.bc0),
    .long_orbit_i   (long_orbit_q),
    .offset_i       (offset_c),
    .count_o        (count_c),
    .captured_o     (cap_c)
  );

  assign count_x            = XW'(count_c);
  assign cap_x              = XW'(cap_c);
  assign crossing_count_o   = count_x[ttc_pkg::OUT_W-1:0];
  assign count_before_bc0_o = cap_x[ttc_pkg::OUT_W-1:0];

  // command flags of the tick held in the result slot
  ttc_pkg::cmd_t seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (in_fire) begin
      seen_q <= cmd;
    end
  end

  assign resync_seen_o = seen_q.resync;
  assign bc0_seen_o    = seen_q.bc0;
  assign start_seen_o  = seen_q.start;
  assign stop_seen_o   = seen_q.stop;

`ifndef NO_ASSERTIONS
  // a hard reset tick leaves triggers stopped and the DAQ reset pulsing
  a_hard_reset_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !hard_reset_n_i) |=> (trigger_stopped_o && daq_counter_reset_o))
    else $error("hard reset did not set stop and DAQ reset flags");

  // BC0 captures the counter value held before the tick
  a_bc0_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hard_reset_n_i && cmd.bc0) |=>
      (count_before_bc0_o == $past(crossing_count_o)))
    else $error("BC0 capture mismatch");

  // the result state only moves on an accepted item
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(crossing_count_o) && $stable(count_before_bc0_o) &&
                  $stable(trigger_stopped_o) && $stable(daq_counter_reset_o)))
    else $error("state changed without an accepted item");
`endif

endmodule
`default_nettype wire

>>> tb/sv/ttc_trigger_sync_fsm_unit_tb.sv
// Self-checking testbench for the TTC trigger sync unit: directed table, then random items.
module ttc_trigger_sync_fsm_unit_tb;
  import ttc_pkg::*;

  // Orbit lengths of the block as instantiated (default parameters).
  localparam int unsigned LONG_ORBIT  = 3564;
  localparam int unsigned SHORT_ORBIT = 924;
  localparam logic [OUT_W-1:0] LONG_TERM  = OUT_W'(LONG_ORBIT - 1);
  localparam logic [OUT_W-1:0] SHORT_TERM = OUT_W'(SHORT_ORBIT - 1);

  // Extreme command codes.
  localparam logic [CODE_W-1:0] CODE_MIN      = 6'd0;
  localparam logic [CODE_W-1:0] CODE_MAX      = 6'd63;

  // Timeout guard on the whole run; the limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 40;

  // One machine tick as presented on the input channel.
  typedef struct packed {
    logic              hard_reset_n;
    logic              test_enable;
    logic [CODE_W-1:0] code;
    logic              strobe;
  } tick_t;

  // One result item, field for field as it leaves the block.
  typedef struct packed {
    logic [OUT_W-1:0] crossing;
    logic             daq;
    logic             stopped;
    logic             resync;
    logic             bc0;
    logic             start;
    logic             stop;
    logic [OUT_W-1:0] captured;
  } sync_res_t;

  // Directed table row; pinned rows carry a hand-written expectation.
  typedef struct packed {
    tick_t     tick;
    logic      pinned;
    sync_res_t want;
  } dir_row_t;

  // DUT inputs, all known from time zero.
  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              cfg_we_i         = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr_i      = '0;
  logic [CFG_W-1:0]  cfg_data_i       = '0;
  logic              in_valid_i       = 1'b0;
  logic              hard_reset_n_i   = 1'b1;
  logic              test_enable_i    = 1'b0;
  logic [CODE_W-1:0] command_code_i   = '0;
  logic              command_strobe_i = 1'b0;
  logic              out_ready_i      = 1'b0;

  logic              in_ready_o;
  logic              out_valid_o;
  logic [OUT_W-1:0]  crossing_count_o;
  logic              daq_counter_reset_o;
  logic              trigger_stopped_o;
  logic              resync_seen_o;
  logic              bc0_seen_o;
  logic              start_seen_o;
  logic              stop_seen_o;
  logic [OUT_W-1:0]  count_before_bc0_o;

  // Side band that travels with the payload: pinned expectation, if any.
  logic              pin_valid_q = 1'b0;
  sync_res_t         pin_res_q   = '0;

  // Model copy of the configuration registers.
  logic [OUT_W-1:0]  cfg_offset_q    = '0;
  logic              cfg_long_q      = 1'b1;
  logic [CODE_W-1:0] cfg_op_resync_q = DEF_OP_RESYNC;
  logic [CODE_W-1:0] cfg_op_bc0_q    = DEF_OP_BC0;
  logic [CODE_W-1:0] cfg_op_start_q  = DEF_OP_START;
  logic [CODE_W-1:0] cfg_op_stop_q   = DEF_OP_STOP;

  // Model copy of the block state.
  run_state_e        sync_state_q = ST_STOP;
  logic [OUT_W-1:0]  xing_cnt_q   = '0;
  logic [OUT_W-1:0]  xing_cap_q   = '0;
  logic              stop_flag_q  = 1'b1;
  logic              daq_flag_q   = 1'b0;

  sync_res_t         expected_results [$];

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count   = 0;
  bit          gaps_on       = 1'b1;
  bit          stall_on      = 1'b1;

  ttc_trigger_sync_fsm_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .hard_reset_n_i      (hard_reset_n_i),
    .test_enable_i       (test_enable_i),
    .command_code_i      (command_code_i),
    .command_strobe_i    (command_strobe_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .crossing_count_o    (crossing_count_o),
    .daq_counter_reset_o (daq_counter_reset_o),
    .trigger_stopped_o   (trigger_stopped_o),
    .resync_seen_o       (resync_seen_o),
    .bc0_seen_o          (bc0_seen_o),
    .start_seen_o        (start_seen_o),
    .stop_seen_o         (stop_seen_o),
    .count_before_bc0_o  (count_before_bc0_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the model by one tick; every decision reads the pre-tick state.
  function automatic sync_res_t predict_sync_tick(input tick_t t);
    logic             is_resync, is_bc0, is_start, is_stop;
    logic [OUT_W-1:0] terminal;
    logic [OUT_W-1:0] nxt_cnt, nxt_cap;
    logic             nxt_stop, nxt_daq;
    run_state_e       nxt_state;
    sync_res_t        r;
    is_resync = t.strobe && (t.code == cfg_op_resync_q);
    is_bc0    = t.strobe && (t.code == cfg_op_bc0_q);
    is_start  = t.strobe && (t.code == cfg_op_start_q);
    is_stop   = t.strobe && (t.code == cfg_op_stop_q);
    terminal  = cfg_long_q ? LONG_TERM : SHORT_TERM;
    nxt_state = sync_state_q;
    nxt_cnt   = xing_cnt_q;
    nxt_cap   = xing_cap_q;
    nxt_stop  = 1'b0;
    nxt_daq   = 1'b0;
    if (!t.hard_reset_n) begin
      // hard reset: no counting, no capture, test enable ignored
      nxt_state = ST_STOP;
      nxt_stop  = 1'b1;
      nxt_daq   = 1'b1;
      nxt_cnt   = cfg_offset_q;
    end else begin
      case (sync_state_q)
        ST_STOP: begin
          nxt_stop = 1'b1;
          if (is_resync) nxt_state = ST_RESYNC;
          else if (is_start) nxt_state = ST_WAIT;
        end
        ST_RESYNC: begin
          // no offset load in this state; the counter update below applies as usual
          nxt_stop  = 1'b1;
          nxt_daq   = 1'b1;
          nxt_state = ST_WAIT;
        end
        ST_WAIT: begin
          nxt_stop = 1'b1;
          if (is_bc0) nxt_state = ST_RUN;
          else if (is_resync) nxt_state = ST_RESYNC;
          else if (is_stop) nxt_state = ST_STOP;
        end
        default: begin
          if (is_stop) nxt_state = ST_STOP;
          else if (is_resync) nxt_state = ST_RESYNC;
        end
      endcase
      if (is_bc0) begin
        nxt_cap = xing_cnt_q;
        nxt_cnt = cfg_offset_q;
      end else if (xing_cnt_q == terminal) begin
        nxt_cnt = '0;
      end else begin
        // above terminal the count runs on and wraps at the counter width
        nxt_cnt = xing_cnt_q + 1'b1;
      end
      if (t.test_enable) nxt_stop = 1'b0;
    end
    sync_state_q = nxt_state;
    xing_cnt_q   = nxt_cnt;
    xing_cap_q   = nxt_cap;
    stop_flag_q  = nxt_stop;
    daq_flag_q   = nxt_daq;
    r.crossing = nxt_cnt;
    r.daq      = nxt_daq;
    r.stopped  = nxt_stop;
    r.resync   = is_resync;
    r.bc0      = is_bc0;
    r.start    = is_start;
    r.stop     = is_stop;
    r.captured = nxt_cap;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("MISMATCH %s", what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  // Scoreboard: results are checked against the oldest expectation, then
  // accepted items are predicted, then register writes update the model.
  always @(posedge clk_i) begin : scoreboard
    sync_res_t got;
    sync_res_t want;
    tick_t     tk;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.crossing = crossing_count_o;
        got.daq      = daq_counter_reset_o;
        got.stopped  = trigger_stopped_o;
        got.resync   = resync_seen_o;
        got.bc0      = bc0_seen_o;
        got.start    = start_seen_o;
        got.stop     = stop_seen_o;
        got.captured = count_before_bc0_o;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("crossing_count", got.crossing, want.crossing);
          check_field("daq_counter_reset", OUT_W'(got.daq), OUT_W'(want.daq));
          check_field("trigger_stopped", OUT_W'(got.stopped), OUT_W'(want.stopped));
          check_field("resync_seen", OUT_W'(got.resync), OUT_W'(want.resync));
          check_field("bc0_seen", OUT_W'(got.bc0), OUT_W'(want.bc0));
          check_field("start_seen", OUT_W'(got.start), OUT_W'(want.start));
          check_field("stop_seen", OUT_W'(got.stop), OUT_W'(want.stop));
          check_field("count_before_bc0", got.captured, want.captured);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        tk.hard_reset_n = hard_reset_n_i;
        tk.test_enable  = test_enable_i;
        tk.code         = command_code_i;
        tk.strobe       = command_strobe_i;
        want = predict_sync_tick(tk);
        // a pinned row is checked against the typed-in value instead
        if (pin_valid_q) want = pin_res_q;
        expected_results.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_OFFSET:     cfg_offset_q    = cfg_data_i;
          CFG_LONG_ORBIT: cfg_long_q      = cfg_data_i[0];
          CFG_OP_RESYNC:  cfg_op_resync_q = cfg_data_i[CODE_W-1:0];
          CFG_OP_BC0:     cfg_op_bc0_q    = cfg_data_i[CODE_W-1:0];
          CFG_OP_START:   cfg_op_start_q  = cfg_data_i[CODE_W-1:0];
          CFG_OP_STOP:    cfg_op_stop_q   = cfg_data_i[CODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk_i) begin : ready_gen
    int unsigned ready_left;
    int unsigned pick;
    if (ready_left != 0) begin
      ready_left--;
    end else if (!stall_on) begin
      out_ready_i <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_ready_i <= 1'b1;
        ready_left = $urandom_range(0, 6);
      end else if (pick < 92) begin
        out_ready_i <= 1'b0;
        ready_left = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_left = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("FAIL ttc_trigger_sync_fsm_unit");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (!gaps_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Present one item and return at the edge where it is accepted. Valid is
  // left high so a back-to-back item never drops it within one step.
  task automatic send_tick(input tick_t t, input logic pinned, input sync_res_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    hard_reset_n_i   <= t.hard_reset_n;
    test_enable_i    <= t.test_enable;
    command_code_i   <= t.code;
    command_strobe_i <= t.strobe;
    pin_valid_q      <= pinned;
    pin_res_q        <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [CODE_W-1:0] code);
    tick_t t;
    t.hard_reset_n = 1'b1;
    t.test_enable  = ($urandom_range(0, 9) == 0);
    t.code         = code;
    t.strobe       = 1'b1;
    send_tick(t, 1'b0, '0);
  endtask

  task automatic send_idle(input int unsigned n);
    tick_t       t;
    logic [31:0] rnd;
    repeat (n) begin
      rnd = $urandom;
      t.hard_reset_n = 1'b1;
      t.test_enable  = ($urandom_range(0, 9) == 0);
      t.code         = rnd[CODE_W-1:0];
      t.strobe       = 1'b0;
      send_tick(t, 1'b0, '0);
    end
  endtask

  // Stop sending and hold off until every expected result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all six registers on consecutive edges; only while idle.
  task automatic apply_settings(input logic [OUT_W-1:0] offs, input logic lng,
                                input logic [CODE_W-1:0] op_rs, input logic [CODE_W-1:0] op_b0,
                                input logic [CODE_W-1:0] op_st, input logic [CODE_W-1:0] op_sp);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_OFFSET;
    cfg_data_i <= offs;
    @(posedge clk_i);
    // upper data bits are don't-care for the narrow registers
    cfg_addr_i <= CFG_LONG_ORBIT;
    cfg_data_i <= {junk[10:0], lng};
    @(posedge clk_i);
    cfg_addr_i <= CFG_OP_RESYNC;
    cfg_data_i <= {junk[16:11], op_rs};
    @(posedge clk_i);
    cfg_addr_i <= CFG_OP_BC0;
    cfg_data_i <= {junk[22:17], op_b0};
    @(posedge clk_i);
    cfg_addr_i <= CFG_OP_START;
    cfg_data_i <= {junk[28:23], op_st};
    @(posedge clk_i);
    cfg_addr_i <= CFG_OP_STOP;
    cfg_data_i <= {~junk[5:0], op_sp};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly well-formed resync/start sequences with runs of
  // crossings, plus command noise, hard resets and out-of-order commands.
  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    bit          quiet;
    tick_t       t;
    logic [31:0] rnd;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      quiet    = ($urandom_range(0, 5) == 0);
      gaps_on  = !quiet;
      stall_on = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_cmd(cfg_op_resync_q);
        send_idle($urandom_range(0, 3));
        send_cmd(cfg_op_bc0_q);
        send_idle($urandom_range(1, 40));
        pick = $urandom_range(0, 3);
        if (pick < 2) send_cmd(cfg_op_stop_q);
        else if (pick == 2) send_cmd(cfg_op_resync_q);
      end else if (pick < 65) begin
        send_cmd(cfg_op_stop_q);
        send_cmd(cfg_op_start_q);
        send_idle($urandom_range(0, 4));
        send_cmd(cfg_op_bc0_q);
        send_idle($urandom_range(1, 20));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 12)) begin
          rnd = $urandom;
          t.hard_reset_n = 1'b1;
          t.test_enable  = ($urandom_range(0, 4) == 0);
          t.code         = rnd[CODE_W-1:0];
          t.strobe       = rnd[8];
          send_tick(t, 1'b0, '0);
        end
      end else begin
        rnd = $urandom;
        t.hard_reset_n = rnd[0];
        t.test_enable  = rnd[1];
        t.strobe       = 1'b1;
        case (rnd[4:2])
          3'd0:    t.code = cfg_op_resync_q;
          3'd1:    t.code = cfg_op_bc0_q;
          3'd2:    t.code = cfg_op_start_q;
          3'd3:    t.code = cfg_op_stop_q;
          default: t.code = rnd[13:8];
        endcase
        send_tick(t, 1'b0, '0);
      end
    end
  endtask

  function automatic dir_row_t dir_row(input logic hr_n, input logic te,
                                       input logic [CODE_W-1:0] code, input logic stb);
    dir_row_t r;
    r.tick.hard_reset_n = hr_n;
    r.tick.test_enable  = te;
    r.tick.code         = code;
    r.tick.strobe       = stb;
    r.pinned            = 1'b0;
    r.want              = '0;
    return r;
  endfunction

  function automatic dir_row_t pinned_row(input dir_row_t row, input sync_res_t want);
    dir_row_t r;
    r        = row;
    r.pinned = 1'b1;
    r.want   = want;
    return r;
  endfunction

  function automatic sync_res_t pin_res(input logic [OUT_W-1:0] cnt, input logic daq,
                                        input logic stopped, input logic rs, input logic b0,
                                        input logic st, input logic sp,
                                        input logic [OUT_W-1:0] cap);
    sync_res_t r;
    r.crossing = cnt;
    r.daq      = daq;
    r.stopped  = stopped;
    r.resync   = rs;
    r.bc0      = b0;
    r.start    = st;
    r.stop     = sp;
    r.captured = cap;
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t    rows [$];
    logic [31:0] rnd;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, reset settings (offset 0, long orbit).
    // Hard reset right after reset: counter loads offset, both flags set.
    rows.push_back(pinned_row(dir_row(1'b0, 1'b0, CODE_MIN, 1'b1),
                              pin_res(12'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0)));
    // Unstrobed max code: plain count, stop flag held in stop state.
    rows.push_back(pinned_row(dir_row(1'b1, 1'b0, CODE_MAX, 1'b0),
                              pin_res(12'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0)));
    // BC0 in stop state: capture 1, reload offset.
    rows.push_back(pinned_row(dir_row(1'b1, 1'b0, DEF_OP_BC0, 1'b1),
                              pin_res(12'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 12'd1)));
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_START, 1'b1));   // stop -> wait
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_STOP, 1'b1));    // wait -> stop
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_RESYNC, 1'b1));  // stop -> resync
    rows.push_back(dir_row(1'b1, 1'b0, CODE_MIN, 1'b0));       // resync -> wait, DAQ reset pulse, plain count
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_RESYNC, 1'b1));  // wait -> resync
    rows.push_back(dir_row(1'b1, 1'b0, CODE_MAX, 1'b0));
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_BC0, 1'b1));     // wait -> run
    rows.push_back(dir_row(1'b1, 1'b1, CODE_MIN, 1'b0));       // test enable in run
    rows.push_back(dir_row(1'b1, 1'b0, CODE_MIN, 1'b0));
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_RESYNC, 1'b1));  // run -> resync
    rows.push_back(dir_row(1'b1, 1'b0, CODE_MIN, 1'b0));
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_BC0, 1'b1));
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_STOP, 1'b1));    // run -> stop
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_RESYNC, 1'b0));  // unstrobed opcode ignored
    rows.push_back(dir_row(1'b1, 1'b1, DEF_OP_START, 1'b1));   // test enable clears stop
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_STOP, 1'b1));
    rows.push_back(dir_row(1'b0, 1'b1, DEF_OP_BC0, 1'b1));     // hard reset beats test enable
    rows.push_back(dir_row(1'b1, 1'b0, CODE_MAX, 1'b1));
    rows.push_back(dir_row(1'b1, 1'b0, CODE_MIN, 1'b1));
    rows.push_back(dir_row(1'b1, 1'b0, DEF_OP_START, 1'b1));
    rows.push_back(dir_row(1'b1, 1'b1, DEF_OP_RESYNC, 1'b1));
    foreach (rows[i]) send_tick(rows[i].tick, rows[i].pinned, rows[i].want);

    run_random(120);
    // Sender holds off mid-phase until the pipe is empty.
    drain_results();
    run_random(130);

    // All opcodes equal at one code; offset above terminal on the short orbit.
    drain_results();
    apply_settings(12'hFFF, 1'b0, 6'd5, 6'd5, 6'd5, 6'd5);
    run_random(250);

    // Offset just below the long terminal count, so orbits wrap quickly.
    drain_results();
    apply_settings(12'd3560, 1'b1, CODE_MAX, CODE_MIN, 6'd62, 6'd1);
    run_random(250);

    drain_results();
    apply_settings(12'd920, 1'b0, CODE_MIN, CODE_MAX, 6'd1, 6'd62);
    run_random(250);

    drain_results();
    rnd = $urandom;
    apply_settings(rnd[11:0], rnd[12], rnd[18:13], rnd[24:19], rnd[30:25],
                   6'($urandom_range(0, 63)));
    run_random(250);

    drain_results();
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Run covered %0d items under %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("Mismatches: %0d, cycles: %0d", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("PASS ttc_trigger_sync_fsm_unit");
    end else begin
      $display("FAIL ttc_trigger_sync_fsm_unit");
    end
    $finish;
  end

endmodule

>>> ttc_trigger_sync_fsm_unit.f
rtl/ttc_pkg.sv
rtl/ttc_cmd_decode.sv
rtl/ttc_sync_fsm.sv
rtl/ttc_bx_counter.sv
rtl/ttc_trigger_sync_fsm_unit.sv
tb/sv/ttc_trigger_sync_fsm_unit_tb.sv
